// ===== hw/rtl/vfc_pkg.sv =====
`timescale 1ns / 1ps

package vfc_pkg;

    localparam int COLOR_BITS = 8;
    localparam int COUNT_BITS = 12;
    localparam int REG_BITS   = 12;
    localparam int PIX_BITS   = 12;
    localparam int CHAN_BITS  = 8;
    localparam int CMP_BITS   = (COUNT_BITS > REG_BITS) ? COUNT_BITS : REG_BITS;

    localparam logic [CHAN_BITS-1:0] COLOR_MASK =
        CHAN_BITS'((1 << COLOR_BITS) - 1);

    // register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_H_ACTIVE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_H_PORCH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_V_ACTIVE = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_V_PORCH  = 2'd3;

    localparam logic [REG_BITS-1:0] H_ACTIVE_RST = REG_BITS'(640);
    localparam logic [REG_BITS-1:0] H_PORCH_RST  = REG_BITS'(48);
    localparam logic [REG_BITS-1:0] V_ACTIVE_RST = REG_BITS'(480);
    localparam logic [REG_BITS-1:0] V_PORCH_RST  = REG_BITS'(33);

    // phase codes, shared by both machines
    localparam logic [1:0] PH_WAIT_LOW  = 2'd0;
    localparam logic [1:0] PH_WAIT_HIGH = 2'd1;
    localparam logic [1:0] PH_PORCH     = 2'd2;
    localparam logic [1:0] PH_ACTIVE    = 2'd3;

    typedef struct packed {
        logic                 hsync;
        logic                 vsync;
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } sample_t;

    typedef struct packed {
        logic                 pixel_valid;
        logic                 frame_end;
        logic [PIX_BITS-1:0]  pixel_x;
        logic [PIX_BITS-1:0]  pixel_y;
        logic [CHAN_BITS-1:0] red;
        logic [CHAN_BITS-1:0] green;
        logic [CHAN_BITS-1:0] blue;
    } result_t;

    typedef struct packed {
        logic                    wen;
        logic [CFG_IDX_BITS-1:0] index;
        logic [REG_BITS-1:0]     wdata;
    } cfg_write_t;

endpackage

// ===== hw/rtl/vfc_sync_track.sv =====
`timescale 1ns / 1ps

module vfc_sync_track import vfc_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_write_t cfg,
    input  logic       accept,
    input  sample_t    sample,
    output result_t    result
);

    logic [REG_BITS-1:0]   h_active_len_reg;
    logic [REG_BITS-1:0]   h_porch_len_reg;
    logic [REG_BITS-1:0]   v_active_len_reg;
    logic [REG_BITS-1:0]   v_porch_len_reg;

    logic [1:0]            h_phase_reg, h_phase_next;
    logic [1:0]            v_phase_reg, v_phase_next;
    logic [COUNT_BITS-1:0] h_count_reg, h_count_next;
    logic [COUNT_BITS-1:0] v_count_reg, v_count_next;

    logic [COUNT_BITS-1:0] h_inc, v_inc;
    logic [REG_BITS-1:0]   h_len, v_len;
    logic                  h_hit, v_hit;
    logic                  v_step;
    logic                  done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_active_len_reg <= H_ACTIVE_RST;
            h_porch_len_reg  <= H_PORCH_RST;
            v_active_len_reg <= V_ACTIVE_RST;
            v_porch_len_reg  <= V_PORCH_RST;
        end else if (cfg.wen) begin
            unique case (cfg.index)
                CFG_H_ACTIVE: h_active_len_reg <= cfg.wdata;
                CFG_H_PORCH:  h_porch_len_reg  <= cfg.wdata;
                CFG_V_ACTIVE: v_active_len_reg <= cfg.wdata;
                CFG_V_PORCH:  v_porch_len_reg  <= cfg.wdata;
                default: ;
            endcase
        end
    end

    // one incrementer and compare per machine; phase picks the length
    assign h_inc = h_count_reg + COUNT_BITS'(1);
    assign v_inc = v_count_reg + COUNT_BITS'(1);
    assign h_len = (h_phase_reg == PH_PORCH) ? h_porch_len_reg : h_active_len_reg;
    assign v_len = (v_phase_reg == PH_PORCH) ? v_porch_len_reg : v_active_len_reg;
    assign h_hit = CMP_BITS'(h_inc) == CMP_BITS'(h_len);
    assign v_hit = CMP_BITS'(v_inc) == CMP_BITS'(v_len);

    always_comb begin
        h_phase_next = h_phase_reg;
        h_count_next = h_count_reg;
        v_step       = 1'b0;
        unique case (h_phase_reg)
            PH_WAIT_LOW: begin
                if (!sample.hsync) h_phase_next = PH_WAIT_HIGH;
            end
            PH_WAIT_HIGH: begin
                if (sample.hsync) begin
                    h_phase_next = PH_PORCH;
                    h_count_next = '0;
                    v_step       = 1'b1;
                end
            end
            PH_PORCH: begin
                h_count_next = h_inc;
                if (h_hit) begin
                    h_phase_next = PH_ACTIVE;
                    h_count_next = '0;
                end
            end
            default: begin
                // hold the count past the line end until the next hsync rise
                h_count_next = h_inc;
                if (h_hit) h_phase_next = PH_WAIT_LOW;
            end
        endcase
    end

    always_comb begin
        v_phase_next = v_phase_reg;
        v_count_next = v_count_reg;
        done         = 1'b0;
        if (v_step) begin
            unique case (v_phase_reg)
                PH_ACTIVE: begin
                    v_count_next = v_inc;
                    if (v_hit) begin
                        v_count_next = '0;
                        v_phase_next = PH_WAIT_LOW;
                    end
                end
                PH_WAIT_LOW: begin
                    if (!sample.vsync) v_phase_next = PH_WAIT_HIGH;
                end
                PH_WAIT_HIGH: begin
                    if (sample.vsync) begin
                        v_phase_next = PH_PORCH;
                        v_count_next = '0;
                    end
                end
                default: begin
                    v_count_next = v_inc;
                    if (v_hit) begin
                        v_phase_next = PH_ACTIVE;
                        v_count_next = '0;
                        done         = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            h_phase_reg <= PH_WAIT_LOW;
            v_phase_reg <= PH_ACTIVE;
            h_count_reg <= '0;
            v_count_reg <= '0;
        end else if (accept) begin
            h_phase_reg <= h_phase_next;
            v_phase_reg <= v_phase_next;
            h_count_reg <= h_count_next;
            v_count_reg <= v_count_next;
        end
    end

    // the write is decided from the state before this sample's update
    always_comb begin
        result             = '0;
        result.frame_end   = done;
        if (h_phase_reg == PH_ACTIVE && v_phase_reg == PH_ACTIVE) begin
            result.pixel_valid = 1'b1;
            result.pixel_x     = PIX_BITS'(h_count_reg);
            result.pixel_y     = PIX_BITS'(v_count_reg);
            result.red         = sample.red & COLOR_MASK;
            result.green       = sample.green & COLOR_MASK;
            result.blue        = sample.blue & COLOR_MASK;
        end
    end

endmodule

// ===== hw/rtl/vga_frame_capture.sv =====
`timescale 1ns / 1ps

// VGA frame capture.
// Input stream: one VGA sample per transaction (sync levels and colour).
// Output stream: exactly one result per sample. m_tuser is high when the
// sample was an active pixel, with column, row and colour in m_tdata (all
// zero otherwise). m_tlast pulses on the sample that ends the vertical
// back porch, i.e. one frame has completed.
// The result for a sample is in the output register in the cycle after
// its transaction. The block takes one sample per cycle while the
// receiver takes results. When the receiver stalls, the output register
// holds its result and s_tready drops until it is taken; s_tready stays
// high while the output register is empty or draining.
// Reset (aresetn low, synchronous) restores the default 640x480 timing
// lengths, puts the horizontal machine into waiting for hsync low and the
// vertical machine into active lines at row 0, and empties the output.
// Row 0 of the first frame after reset is not captured.
// Timing lengths must be written through the cfg port while the stream
// idles; the user is bound by this, the block does not enforce it.

module vga_frame_capture import vfc_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wen,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [REG_BITS-1:0]     cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // hsync, vsync, red_in, green_in, blue_in, zero fill
    input  logic [31:0]             s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // pixel_x, pixel_y, red_out, green_out, blue_out
    output logic [47:0]             m_tdata,
    // pixel_valid
    output logic                    m_tuser,
    // frame_end
    output logic                    m_tlast
);

    cfg_write_t cfg;
    sample_t    sample;
    result_t    result;
    result_t    out_reg;
    logic       out_valid_reg;
    logic       accept;

    assign cfg.wen   = cfg_wen;
    assign cfg.index = cfg_index;
    assign cfg.wdata = cfg_wdata;

    assign sample.hsync = s_tdata[0];
    assign sample.vsync = s_tdata[1];
    assign sample.red   = s_tdata[9:2];
    assign sample.green = s_tdata[17:10];
    assign sample.blue  = s_tdata[25:18];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    vfc_sync_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .accept  (accept),
        .sample  (sample),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_tready) begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.pixel_valid;
    assign m_tlast  = out_reg.frame_end;
    assign m_tdata  = {out_reg.blue, out_reg.green, out_reg.red,
                       out_reg.pixel_y, out_reg.pixel_x};

endmodule

// ===== hw/rtl/vfc_checker.sv =====
`timescale 1ns / 1ps

module vfc_checker import vfc_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    // a stalled result holds until taken
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled result changed");

    // a non-pixel result carries no coordinates or colour
    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("non-pixel result with data");

    // frame end falls in the horizontal sync, never on an active pixel
    a_done_not_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser && m_tlast))
        else $error("frame end on an active pixel");

    // an empty output register never blocks the input
    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind vga_frame_capture vfc_checker u_vfc_checker (.*);

// ===== dv/tb_vga_frame_capture.sv =====
`timescale 1ns / 1ps

module tb_vga_frame_capture;
    import vfc_pkg::*;

    localparam int IDLE_PCT = 35;
    localparam int MAX_REPORTS = 10;
    localparam int RANDOM_ITEMS = 700;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wen = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [REG_BITS-1:0]     cfg_wdata = '0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    // hsync, vsync, red_in, green_in, blue_in, zero fill
    logic [31:0]             s_tdata = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    // pixel_x, pixel_y, red_out, green_out, blue_out
    logic [47:0]             m_tdata;
    // pixel_valid
    logic                    m_tuser;
    // frame_end
    logic                    m_tlast;

    // timing lengths and machine state of the capture, as the block should hold them
    logic [REG_BITS-1:0]   len_h_act;
    logic [REG_BITS-1:0]   len_h_porch;
    logic [REG_BITS-1:0]   len_v_act;
    logic [REG_BITS-1:0]   len_v_porch;
    logic [1:0]            h_ph;
    logic [1:0]            v_ph;
    logic [COUNT_BITS-1:0] h_cnt;
    logic [COUNT_BITS-1:0] v_cnt;

    sample_t     vga_samples[$];
    result_t     expected_pixels[$];
    sample_t     sample_on_bus;
    int unsigned samples_pushed = 0;
    int unsigned samples_returned = 0;
    int unsigned mismatches = 0;
    bit          full_rate = 1'b0;
    bit          hold_done = 1'b0;
    int unsigned hold_left = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    vga_frame_capture i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // one step of the line machine, taken on every hsync rise
    task automatic step_lines(input logic vs, output logic done);
        done = 1'b0;
        case (v_ph)
            PH_ACTIVE: begin
                v_cnt = v_cnt + 1'b1;
                if (v_cnt == len_v_act) begin
                    v_cnt = '0;
                    v_ph = PH_WAIT_LOW;
                end
            end
            PH_WAIT_LOW: begin
                if (!vs) v_ph = PH_WAIT_HIGH;
            end
            PH_WAIT_HIGH: begin
                if (vs) begin
                    v_ph = PH_PORCH;
                    v_cnt = '0;
                end
            end
            default: begin
                v_cnt = v_cnt + 1'b1;
                if (v_cnt == len_v_porch) begin
                    v_ph = PH_ACTIVE;
                    v_cnt = '0;
                    done = 1'b1;
                end
            end
        endcase
    endtask

    task automatic capture_sample(input sample_t smp, output result_t res);
        logic done;
        res = '0;
        done = 1'b0;
        // the write is decided from the state before this sample
        if (h_ph == PH_ACTIVE && v_ph == PH_ACTIVE) begin
            res.pixel_valid = 1'b1;
            res.pixel_x = h_cnt;
            res.pixel_y = v_cnt;
            res.red = smp.red & COLOR_MASK;
            res.green = smp.green & COLOR_MASK;
            res.blue = smp.blue & COLOR_MASK;
        end
        case (h_ph)
            PH_WAIT_LOW: begin
                if (!smp.hsync) h_ph = PH_WAIT_HIGH;
            end
            PH_WAIT_HIGH: begin
                if (smp.hsync) begin
                    h_ph = PH_PORCH;
                    h_cnt = '0;
                    step_lines(smp.vsync, done);
                end
            end
            PH_PORCH: begin
                h_cnt = h_cnt + 1'b1;
                if (h_cnt == len_h_porch) begin
                    h_ph = PH_ACTIVE;
                    h_cnt = '0;
                end
            end
            default: begin
                // h_cnt keeps its value until the next hsync rise
                h_cnt = h_cnt + 1'b1;
                if (h_cnt == len_h_act) h_ph = PH_WAIT_LOW;
            end
        endcase
        res.frame_end = done;
    endtask

    function automatic string fmt_pixel(input result_t p);
        return $sformatf("valid=%0d done=%0d x=%0d y=%0d rgb=%02h/%02h/%02h",
                         p.pixel_valid, p.frame_end, p.pixel_x, p.pixel_y,
                         p.red, p.green, p.blue);
    endfunction

    // sample driver: predict on every accepted transaction, then offer the next one
    always @(posedge aclk) begin : drive_samples
        result_t pix;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                capture_sample(sample_on_bus, pix);
                expected_pixels.push_back(pix);
            end
            if (vga_samples.size() != 0 && (full_rate || $urandom_range(99) >= IDLE_PCT)) begin
                sample_on_bus = vga_samples.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {6'b0, sample_on_bus.blue, sample_on_bus.green,
                            sample_on_bus.red, sample_on_bus.vsync, sample_on_bus.hsync};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off to back the block up
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else if (!hold_done && samples_returned >= 300) begin
            hold_done <= 1'b1;
            hold_left <= 150;
            m_tready <= 1'b0;
        end else begin
            m_tready <= full_rate || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin : check_pixels
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = '0;
            got.pixel_valid = m_tuser;
            got.frame_end = m_tlast;
            got.pixel_x = m_tdata[11:0];
            got.pixel_y = m_tdata[23:12];
            got.red = m_tdata[31:24];
            got.green = m_tdata[39:32];
            got.blue = m_tdata[47:40];
            samples_returned++;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing pending: %s", $time, fmt_pixel(got));
            end else begin
                want = expected_pixels.pop_front();
                if (got.pixel_valid !== want.pixel_valid || got.frame_end !== want.frame_end ||
                    got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
                    got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: expected %s, got %s", $time,
                                 fmt_pixel(want), fmt_pixel(got));
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int val);
        @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= REG_BITS'(val);
        case (idx)
            CFG_H_ACTIVE: len_h_act = REG_BITS'(val);
            CFG_H_PORCH:  len_h_porch = REG_BITS'(val);
            CFG_V_ACTIVE: len_v_act = REG_BITS'(val);
            default:      len_v_porch = REG_BITS'(val);
        endcase
    endtask

    task automatic set_timing(input int ha, input int hp, input int va, input int vp);
        write_reg(CFG_H_ACTIVE, ha);
        write_reg(CFG_H_PORCH, hp);
        write_reg(CFG_V_ACTIVE, va);
        write_reg(CFG_V_PORCH, vp);
        @(posedge aclk);
        cfg_wen <= 1'b0;
        @(negedge aclk);
    endtask

    // hold until every sample is taken and every result checked
    task automatic wait_idle();
        while (vga_samples.size() != 0 || s_tvalid || expected_pixels.size() != 0)
            @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic push_sample(input bit hs, input bit vs, input logic [7:0] r,
                               input logic [7:0] g, input logic [7:0] b);
        sample_t smp;
        smp.hsync = hs;
        smp.vsync = vs;
        smp.red = r;
        smp.green = g;
        smp.blue = b;
        vga_samples.push_back(smp);
        samples_pushed++;
    endtask

    // a line: hsync low, then n_high samples with hsync high; vsync counts at the rise only
    task automatic push_line(input bit vs, input int n_high);
        int n_low;
        n_low = $urandom_range(1, 2);
        repeat (n_low)
            push_sample(1'b0, 1'($urandom_range(1)), 8'($urandom), 8'($urandom),
                        8'($urandom));
        push_sample(1'b1, vs, 8'($urandom), 8'($urandom), 8'($urandom));
        repeat (n_high - 1)
            push_sample(1'b1, 1'($urandom_range(1)), 8'($urandom), 8'($urandom),
                        8'($urandom));
    endtask

    task automatic push_frame(input int ha, input int hp, input int va, input int vp);
        int n_low_lines;
        int line_len;
        n_low_lines = $urandom_range(1, 2);
        for (int ln = 0; ln < va + n_low_lines + vp + 1; ln++) begin
            line_len = hp + ha + $urandom_range(0, 2);
            // cut a line short now and then
            if ($urandom_range(9) == 0) line_len = $urandom_range(1, hp + ha);
            push_line(!(ln >= va && ln < va + n_low_lines), line_len);
        end
    endtask

    initial begin : stimulus
        int phase_mark;
        int random_mark;
        int ha;
        int hp;
        int va;
        int vp;
        len_h_act = H_ACTIVE_RST;
        len_h_porch = H_PORCH_RST;
        len_v_act = V_ACTIVE_RST;
        len_v_porch = V_PORCH_RST;
        h_ph = PH_WAIT_LOW;
        v_ph = PH_ACTIVE;
        h_cnt = '0;
        v_cnt = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // short lines and frames; row 0 is skipped on the first frame
        set_timing(2, 1, 2, 1);
        push_sample(1'b0, 1'b1, 8'h00, 8'h00, 8'h00);
        push_sample(1'b1, 1'b1, 8'hff, 8'hff, 8'hff);
        push_sample(1'b1, 1'b0, 8'hff, 8'h00, 8'hff);
        push_sample(1'b1, 1'b1, 8'hff, 8'hff, 8'hff);
        push_sample(1'b1, 1'b0, 8'h00, 8'h00, 8'h00);
        push_sample(1'b1, 1'b1, 8'h00, 8'hff, 8'h00);
        push_line(1'b1, 3);
        push_line(1'b0, 3);
        push_line(1'b1, 3);
        push_line(1'b1, 3);
        push_line(1'b1, 4);
        wait_idle();

        // random timings, mostly well-formed frames with some noise
        random_mark = samples_pushed;
        for (int ph = 0; samples_pushed - random_mark < RANDOM_ITEMS; ph++) begin
            if (ph == 0) begin
                ha = 1; hp = 1; va = 1; vp = 1;
            end else begin
                ha = $urandom_range(1, 12);
                hp = $urandom_range(1, 4);
                va = $urandom_range(1, 5);
                vp = $urandom_range(1, 3);
            end
            set_timing(ha, hp, va, vp);
            phase_mark = samples_pushed;
            while (samples_pushed - phase_mark < 150) begin
                if ($urandom_range(99) < 15) begin
                    repeat ($urandom_range(3, 10))
                        push_sample(1'($urandom_range(1)), 1'($urandom_range(1)),
                                    8'($urandom), 8'($urandom), 8'($urandom));
                end else begin
                    push_frame(ha, hp, va, vp);
                end
            end
            wait_idle();
        end

        // a stretch at full rate on both sides
        full_rate = 1'b1;
        set_timing(6, 2, 3, 2);
        repeat (2) push_frame(6, 2, 3, 2);
        wait_idle();
        full_rate = 1'b0;

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
